/* design/crcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crcp_pkg;

    localparam int POSITION_WIDTH_DEF = 32;

    // Descriptor queue between the planner and the output channel
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // CIGAR operation codes
    localparam logic [3:0] KIND_M  = 4'd0;
    localparam logic [3:0] KIND_I  = 4'd1;
    localparam logic [3:0] KIND_D  = 4'd2;
    localparam logic [3:0] KIND_N  = 4'd3;
    localparam logic [3:0] KIND_S  = 4'd4;
    localparam logic [3:0] KIND_H  = 4'd5;
    localparam logic [3:0] KIND_P  = 4'd6;
    localparam logic [3:0] KIND_EQ = 4'd7;
    localparam logic [3:0] KIND_X  = 4'd8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_OVERRUN = 2'd2
    } status_t;

    typedef struct packed {
        logic        copy_source;
        logic [31:0] source_start;
        logic [31:0] dest_start;
        logic [31:0] copy_length;
        status_t     status;
        logic        last;
    } desc_t;

    // Descriptors produced by one accepted operation, in output order
    typedef struct packed {
        logic [1:0] count;
        desc_t      first;
        desc_t      second;
    } plan_t;

endpackage

`default_nettype wire

/* design/crcp_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface crcp_op_if;
    logic        valid;
    logic        ready;
    logic [27:0] op_length;
    logic [3:0]  op_kind;
    logic        last_op;

    modport source (output valid, output op_length, output op_kind, output last_op,
                    input ready);
    modport sink   (input valid, input op_length, input op_kind, input last_op,
                    output ready);
endinterface

interface crcp_desc_if;
    logic        valid;
    logic        ready;
    logic        copy_source;
    logic [31:0] source_start;
    logic [31:0] dest_start;
    logic [31:0] copy_length;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output copy_source, output source_start,
                    output dest_start, output copy_length, output status,
                    output last, input ready);
    modport sink   (input valid, input copy_source, input source_start,
                    input dest_start, input copy_length, input status,
                    input last, output ready);
endinterface

`default_nettype wire

/* design/crcp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module crcp_core
    import crcp_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [27:0] op_length,
    input  wire logic [3:0]  op_kind,
    input  wire logic        last_op,
    input  wire logic [31:0] output_length,
    output plan_t            plan
);

    localparam int PW = POSITION_WIDTH;
    localparam int LW = (PW > 32) ? PW : 32;
    localparam int CW = (PW > 28) ? PW : 28;

    logic [PW-1:0] ref_reg, ref_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW-1:0] out_reg, out_next;
    status_t       err_reg, err_next;

    logic [LW-1:0] ol_w, pmax_w, lim_w;
    logic [PW-1:0] limit, room, room_tail, len_p;
    logic [CW-1:0] len_c, room_c;
    logic          is_ins, is_del, is_ref, over, own_v;
    desc_t         own, tail;

    // limit = output_length capped to the largest position value
    always_comb
    begin
        ol_w   = LW'(output_length);
        pmax_w = LW'({PW{1'b1}});
        lim_w  = (ol_w < pmax_w) ? ol_w : pmax_w;
        limit  = lim_w[PW-1:0];
    end

    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        is_ref = 1'b0;
        unique case (op_kind)
            KIND_I:                                   is_ins = 1'b1;
            KIND_D:                                   is_del = 1'b1;
            KIND_M, KIND_S, KIND_H, KIND_P, KIND_EQ:  is_ref = 1'b1;
            default:                                  ;
        endcase
    end

    always_comb
    begin
        len_c     = CW'(op_length);
        len_p     = len_c[PW-1:0];
        room      = (limit > out_reg) ? (limit - out_reg) : '0;
        room_c    = CW'(room);
        over      = (len_c > room_c);

        ref_next  = ref_reg;
        rd_next   = rd_reg;
        out_next  = out_reg;
        err_next  = err_reg;
        room_tail = room;
        own_v     = 1'b0;
        own       = '0;

        if (err_reg == ST_OK)
        begin
            if (is_del)
            begin
                ref_next = ref_reg + len_p;
            end
            else if (is_ins || is_ref)
            begin
                own_v            = 1'b1;
                own.copy_source  = is_ins;
                own.source_start = is_ins ? 32'(rd_reg) : 32'(ref_reg);
                own.dest_start   = 32'(out_reg);
                if (over)
                begin
                    own.copy_length = 32'(room);
                    own.status      = ST_OVERRUN;
                    err_next        = ST_OVERRUN;
                end
                else
                begin
                    own.copy_length = 32'(op_length);
                    own.status      = ST_OK;
                    rd_next         = rd_reg + len_p;
                    out_next        = out_reg + len_p;
                    room_tail       = room - len_p;
                    if (is_ref)
                        ref_next = ref_reg + len_p;
                end
            end
            else
            begin
                own_v      = 1'b1;
                own.status = ST_UNKNOWN;
                err_next   = ST_UNKNOWN;
            end
        end

        // Tail descriptor sees the state left by this operation
        tail      = '0;
        tail.last = 1'b1;
        if (err_next == ST_OK)
        begin
            tail.source_start = 32'(ref_next);
            tail.dest_start   = 32'(out_next);
            tail.copy_length  = 32'(room_tail);
            tail.status       = ST_OK;
        end
        else
        begin
            tail.status = err_next;
        end

        plan.count  = accept ? (2'(own_v) + 2'(last_op)) : 2'd0;
        plan.first  = own_v ? own : tail;
        plan.second = tail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= '0;
            rd_reg  <= '0;
            out_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (accept)
        begin
            if (last_op)
            begin
                ref_reg <= '0;
                rd_reg  <= '0;
                out_reg <= '0;
                err_reg <= ST_OK;
            end
            else
            begin
                ref_reg <= ref_next;
                rd_reg  <= rd_next;
                out_reg <= out_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

/* design/crcp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module crcp_queue
    import crcp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire plan_t plan,
    output logic       room_ok,
    output logic       out_valid,
    input  wire logic  out_ready,
    output desc_t      out_data
);

    desc_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic [QUEUE_AW-1:0] wr_ptr_1;
    logic                pop;

    // room for two entries: a last operation can push a pair
    assign room_ok   = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_1  = wr_ptr_reg + QUEUE_AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(plan.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + QUEUE_CW'(plan.count) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (plan.count != 2'd0)
            mem_reg[wr_ptr_reg] <= plan.first;
        if (plan.count == 2'd2)
            mem_reg[wr_ptr_1] <= plan.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/cigar_reference_copy_planner.sv */
// CIGAR reference copy planner. Each CIGAR operation transfer (length, kind,
// last flag) is turned into copy descriptors that rebuild a read-aligned
// reference: insertions copy from the read buffer, deletions only move the
// reference position, M/S/H/P/= copy from the reference buffer; the last
// operation adds a tail descriptor (marked last) for the rest of the output
// and clears all positions. Unknown kinds (N, X, codes 9 to 15) report
// status 1 once and silence the alignment until its last operation; a copy
// past output_length is clipped and reports status 2. Rate: one operation
// per cycle while the queue has room and each yields at most one
// descriptor; a last operation with its own descriptor yields two, sent
// one at a time. The descriptors are written into a four-entry queue at
// the transfer and leave from its head; the queue takes an operation
// whenever it has two free entries, so the input keeps moving while the
// output stalls briefly. Write output_length only while no alignment is in
// flight and the output is drained.
`timescale 1ns / 1ps
`default_nettype none

module cigar_reference_copy_planner
    import crcp_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    crcp_op_if.sink          op,
    crcp_desc_if.source      desc
);

    logic [31:0] output_length_reg;
    logic        accept;
    logic        room_ok;
    plan_t       plan;
    desc_t       head;

    // Config register, reset to one byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            output_length_reg <= 32'd1;
        else if (cfg_we)
            output_length_reg <= cfg_wdata;
    end

    // Input transfer: planner state moves and descriptors go to the queue
    assign op.ready = room_ok;
    assign accept   = op.valid && room_ok;

    crcp_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op_length     (op.op_length),
        .op_kind       (op.op_kind),
        .last_op       (op.last_op),
        .output_length (output_length_reg),
        .plan          (plan)
    );

    crcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .plan      (plan),
        .room_ok   (room_ok),
        .out_valid (desc.valid),
        .out_ready (desc.ready),
        .out_data  (head)
    );

    // Head of queue drives the output channel
    assign desc.copy_source  = head.copy_source;
    assign desc.source_start = head.source_start;
    assign desc.dest_start   = head.dest_start;
    assign desc.copy_length  = head.copy_length;
    assign desc.status       = head.status;
    assign desc.last         = head.last;

endmodule

`default_nettype wire

/* design/crcp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module crcp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_last_op,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_copy_source,
    input wire logic [31:0] out_source_start,
    input wire logic [31:0] out_dest_start,
    input wire logic [31:0] out_copy_length,
    input wire logic [1:0]  out_status,
    input wire logic        out_last
);

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_copy_source) && $stable(out_source_start)
            && $stable(out_dest_start) && $stable(out_copy_length)
            && $stable(out_status) && $stable(out_last))
        else $error("output payload changed while stalled");

    // Input only backs up behind pending results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // A last operation always queues a tail descriptor
    a_tail_queued: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last_op |=> out_valid)
        else $error("no result after last operation transfer");

endmodule

bind cigar_reference_copy_planner crcp_checker u_crcp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (op.valid),
    .in_ready         (op.ready),
    .in_last_op       (op.last_op),
    .out_valid        (desc.valid),
    .out_ready        (desc.ready),
    .out_copy_source  (desc.copy_source),
    .out_source_start (desc.source_start),
    .out_dest_start   (desc.dest_start),
    .out_copy_length  (desc.copy_length),
    .out_status       (desc.status),
    .out_last         (desc.last)
);

`default_nettype wire
